>>> rtl/core/lrast_pkg.sv
// Shared types and constants of the line rasterizer.
package lrast_pkg;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam int  VIEW_BITS = 12;
	localparam int  REG_ADDR_BITS = 1;
	localparam logic [REG_ADDR_BITS-1:0] REG_VIEW_WIDTH  = 1'b0;
	localparam logic [REG_ADDR_BITS-1:0] REG_VIEW_HEIGHT = 1'b1;
	localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RST  = 12'd1280;
	localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RST = 12'd720;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/core/lrast_front.sv
// Front end: accepts command words and computes the line setup.
module lrast_front #(
	parameter int COORD_BITS = 12,
	parameter int IN_BITS    = 72,
	parameter int ENTRY_BITS = 108
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,
	input  logic [IN_BITS-1:0]    s_tdata,
	input  lrast_pkg::q_status_t  q_status,
	output logic                  q_push,
	output logic [ENTRY_BITS-1:0] q_data
);

	localparam int W  = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	typedef struct packed {
		logic                 cmd;
		logic                 y_major;
		logic                 minor_neg;
		logic signed [W-1:0]  cur_major;
		logic signed [W-1:0]  cur_minor;
		logic signed [W-1:0]  end_major;
		logic signed [EW-1:0] err;
		logic signed [EW-1:0] inc_diag;
		logic signed [EW-1:0] inc_axial;
		logic [23:0]          color;
	} entry_t;

	logic signed [W-1:0] x0, y0, x1, y1;
	logic [W-1:0]        adx, ady;
	logic                y_major;
	logic                take;

	logic                valid_s1;
	logic                cmd_s1;
	logic                y_major_s1;
	logic signed [W-1:0] maj0_s1, maj1_s1, min0_s1, min1_s1;
	logic [W-1:0]        dmaj_s1, dmin_s1;
	logic [23:0]         color_s1;

	logic                 swap;
	logic signed [EW-1:0] two_dmin, two_dmaj, one_dmaj;
	entry_t               entry;

	assign x0 = s_tdata[W-1:0];
	assign y0 = s_tdata[2*W-1:W];
	assign x1 = s_tdata[3*W-1:2*W];
	assign y1 = s_tdata[4*W-1:3*W];

	assign adx     = (x1 >= x0) ? W'(x1 - x0) : W'(x0 - x1);
	assign ady     = (y1 >= y0) ? W'(y1 - y0) : W'(y0 - y1);
	assign y_major = !(adx > ady);

	assign s_tready = !valid_s1 || !q_status.full;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1     <= s_tuser;
			y_major_s1 <= y_major;
			maj0_s1    <= y_major ? y0 : x0;
			maj1_s1    <= y_major ? y1 : x1;
			min0_s1    <= y_major ? x0 : y0;
			min1_s1    <= y_major ? x1 : y1;
			dmaj_s1    <= y_major ? ady : adx;
			dmin_s1    <= y_major ? adx : ady;
			color_s1   <= {s_tdata[4*W+7:4*W], s_tdata[4*W+15:4*W+8], s_tdata[4*W+23:4*W+16]};
		end
	end

	assign swap     = maj0_s1 > maj1_s1;
	assign two_dmin = {2'b00, dmin_s1, 1'b0};
	assign two_dmaj = {2'b00, dmaj_s1, 1'b0};
	assign one_dmaj = {3'b000, dmaj_s1};

	always_comb begin
		entry.cmd       = cmd_s1;
		entry.y_major   = y_major_s1;
		entry.minor_neg = swap ? (min0_s1 < min1_s1) : (min1_s1 < min0_s1);
		entry.cur_major = swap ? maj1_s1 : maj0_s1;
		entry.cur_minor = swap ? min1_s1 : min0_s1;
		entry.end_major = swap ? maj0_s1 : maj1_s1;
		entry.err       = two_dmin - one_dmaj;
		entry.inc_diag  = two_dmin - two_dmaj;
		entry.inc_axial = two_dmin;
		entry.color     = color_s1;
	end

	assign q_push = valid_s1 && !q_status.full;
	assign q_data = entry;

endmodule

>>> rtl/core/lrast_queue.sv
// Short first-word-fall-through queue between front and back end.
module lrast_queue #(
	parameter int DATA_BITS = 108
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] rd_data,
	output lrast_pkg::q_status_t status
);

	localparam int DEPTH = lrast_pkg::QUEUE_DEPTH;
	localparam int PW    = lrast_pkg::QUEUE_PTR_BITS;

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [PW:0]          count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = count_q == (PW+1)'(DEPTH);
	assign status.empty = count_q == '0;

endmodule

>>> rtl/core/lrast_back.sv
// Back end: holds line state, steps the line and drives the pixel output.
module lrast_back #(
	parameter int COORD_BITS = 12,
	parameter int OUT_BITS   = 48,
	parameter int ENTRY_BITS = 108
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lrast_pkg::REG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [lrast_pkg::VIEW_BITS-1:0]       cfg_wdata,
	input  lrast_pkg::q_status_t                  q_status,
	input  logic [ENTRY_BITS-1:0]                 q_data,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic                                  m_tuser,
	output logic                                  m_tlast,
	output logic [OUT_BITS-1:0]                   m_tdata
);

	localparam int W  = COORD_BITS;
	localparam int EW = COORD_BITS + 3;
	localparam int VB = lrast_pkg::VIEW_BITS;
	localparam int CW = (W > VB) ? W : VB;

	typedef struct packed {
		logic                 cmd;
		logic                 y_major;
		logic                 minor_neg;
		logic signed [W-1:0]  cur_major;
		logic signed [W-1:0]  cur_minor;
		logic signed [W-1:0]  end_major;
		logic signed [EW-1:0] err;
		logic signed [EW-1:0] inc_diag;
		logic signed [EW-1:0] inc_axial;
		logic [23:0]          color;
	} entry_t;

	entry_t entry;

	logic [VB-1:0]        view_width_q, view_height_q;
	logic                 active_q;
	logic                 y_major_q, minor_neg_q;
	logic signed [W-1:0]  cur_major_q, cur_minor_q, end_major_q;
	logic signed [EW-1:0] err_q, inc_diag_q, inc_axial_q;
	logic [23:0]          color_q;

	logic                out_valid_q, out_user_q, out_last_q;
	logic [OUT_BITS-1:0] out_data_q;

	logic                out_free, is_start, emit, last, vis;
	logic signed [W-1:0] px, py;

	assign entry    = q_data;
	assign out_free = !out_valid_q || m_tready;
	assign is_start = entry.cmd == lrast_pkg::CMD_START;
	assign q_pop    = !q_status.empty && (is_start || !active_q || out_free);
	assign emit     = q_pop && !is_start && active_q;

	assign px   = y_major_q ? cur_minor_q : cur_major_q;
	assign py   = y_major_q ? cur_major_q : cur_minor_q;
	assign last = cur_major_q >= end_major_q;
	assign vis  = !px[W-1] && !py[W-1] &&
		(CW'($unsigned(px)) < CW'(view_width_q)) &&
		(CW'($unsigned(py)) < CW'(view_height_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= lrast_pkg::VIEW_WIDTH_RST;
			view_height_q <= lrast_pkg::VIEW_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lrast_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_wdata;
				lrast_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && is_start) active_q <= 1'b1;
			else if (emit && last) active_q <= 1'b0;
			if (emit)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && is_start) begin
			y_major_q   <= entry.y_major;
			minor_neg_q <= entry.minor_neg;
			cur_major_q <= entry.cur_major;
			cur_minor_q <= entry.cur_minor;
			end_major_q <= entry.end_major;
			err_q       <= entry.err;
			inc_diag_q  <= entry.inc_diag;
			inc_axial_q <= entry.inc_axial;
			color_q     <= entry.color;
		end else if (emit && !last) begin
			cur_major_q <= cur_major_q + 1'b1;
			if (err_q > EW'(0)) begin
				cur_minor_q <= minor_neg_q ? cur_minor_q - 1'b1 : cur_minor_q + 1'b1;
				err_q       <= err_q + inc_diag_q;
			end else begin
				err_q <= err_q + inc_axial_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= OUT_BITS'({color_q[7:0], color_q[15:8], color_q[23:16], py, px});
			out_user_q <= vis;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/core/line_rasterizer_top.sv
// Top level of the Bresenham line rasterizer.
//
// Input stream (s_*): s_tuser is the command, 0 starts a line from the endpoints and
// color in s_tdata, 1 asks for the next pixel of the active line. A start word gives
// no output; a pixel request with no active line is dropped without output.
// Output stream (m_*): one word per pixel, m_tlast marks the far endpoint, m_tuser is
// set when the pixel lies inside the viewport set by the view_width / view_height
// registers (cfg_addr 0 and 1, written whenever cfg_we is high).
// A pixel request passes the setup register, a queue slot and the output register before
// it shows on m_tvalid. Throughput: one word per cycle both ways while m_tready is high;
// each pixel is one add and compare on the line state in the back end.
// A four-word queue separates setup from stepping. When m_tready stays low the output
// word holds, the queue fills and s_tready drops once the queue is full and the setup
// register holds a word.
// Reset clears the queue, the active line and the output; the viewport registers
// return to 1280 by 720.
module line_rasterizer_top #(
	parameter int COORD_BITS = 12,
	localparam int IN_BITS    = ((4 * COORD_BITS + 24 + 7) / 8) * 8,
	localparam int OUT_BITS   = ((2 * COORD_BITS + 24 + 7) / 8) * 8,
	localparam int ENTRY_BITS = 6 * COORD_BITS + 36
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lrast_pkg::REG_ADDR_BITS-1:0] cfg_addr,
	input  logic [lrast_pkg::VIEW_BITS-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                s_tuser,   // command
	input  logic [IN_BITS-1:0]                  s_tdata,   // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic                                m_tuser,   // visible
	output logic                                m_tlast,
	output logic [OUT_BITS-1:0]                 m_tdata    // pixel_x, pixel_y, red_out, green_out, blue_out
);

	logic                 q_push, q_pop;
	logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;
	lrast_pkg::q_status_t q_status;

	lrast_front #(
		.COORD_BITS(COORD_BITS),
		.IN_BITS(IN_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.q_status(q_status),
		.q_push(q_push),
		.q_data(q_wr_data)
	);

	lrast_queue #(
		.DATA_BITS(ENTRY_BITS)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_data(q_wr_data),
		.pop(q_pop),
		.rd_data(q_rd_data),
		.status(q_status)
	);

	lrast_back #(
		.COORD_BITS(COORD_BITS),
		.OUT_BITS(OUT_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.q_status(q_status),
		.q_data(q_rd_data),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.m_tdata(m_tdata)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_status.full)
		else $error("input stalled while queue has room");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue pushed while full");

	a_status_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

endmodule

>>> sim/line_rasterizer_top_test.sv
// Self-checking testbench of the line rasterizer: streams start and step words, predicts pixels.
module line_rasterizer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB    = 12;
	localparam int IN_W  = 72;
	localparam int OUT_W = 48;

	typedef struct packed {
		logic          cmd;
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		logic [7:0]    r;
		logic [7:0]    g;
		logic [7:0]    b;
	} line_cmd_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [7:0]    r;
		logic [7:0]    g;
		logic [7:0]    b;
		logic          vis;
		logic          last;
	} pixel_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [lrast_pkg::REG_ADDR_BITS-1:0] cfg_addr  = '0;
	logic [lrast_pkg::VIEW_BITS-1:0]     cfg_wdata = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic                                s_tuser   = 1'b0;
	logic [IN_W-1:0]                     s_tdata   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic                                m_tuser;
	logic                                m_tlast;
	logic [OUT_W-1:0]                    m_tdata;

	line_rasterizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tdata  (m_tdata)
	);

	line_cmd_t pending_cmds[$];
	pixel_t    expected_pixels[$];
	line_cmd_t drv_cmd;
	int        src_idle_pct   = 0;
	int        sink_stall_pct = 0;
	int        err_cnt        = 0;

	// predictor copy of the viewport and the line state
	logic [lrast_pkg::VIEW_BITS-1:0] view_w = lrast_pkg::VIEW_WIDTH_RST;
	logic [lrast_pkg::VIEW_BITS-1:0] view_h = lrast_pkg::VIEW_HEIGHT_RST;
	logic                 ln_active    = 1'b0;
	logic signed [CB-1:0] ln_major     = '0;
	logic signed [CB-1:0] ln_minor     = '0;
	logic signed [CB-1:0] ln_major_end = '0;
	logic signed [14:0]   ln_err       = '0;
	logic [12:0]          ln_dmaj      = '0;
	logic [12:0]          ln_dmin      = '0;
	logic                 ln_minor_neg = 1'b0;
	logic                 ln_y_major   = 1'b0;
	logic [23:0]          ln_color     = '0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic rasterize_cmd(input line_cmd_t c);
		int x0, y0, x1, y1, adx, ady, maj0, maj1, mn0, mn1, t, px, py, e, dn, dj;
		logic at_end;
		pixel_t p;
		if (c.cmd == lrast_pkg::CMD_START) begin
			x0 = int'($signed(c.sx));
			y0 = int'($signed(c.sy));
			x1 = int'($signed(c.ex));
			y1 = int'($signed(c.ey));
			adx = x1 >= x0 ? x1 - x0 : x0 - x1;
			ady = y1 >= y0 ? y1 - y0 : y0 - y1;
			ln_y_major = !(adx > ady);
			if (ln_y_major) begin
				maj0 = y0; maj1 = y1; mn0 = x0; mn1 = x1;
			end else begin
				maj0 = x0; maj1 = x1; mn0 = y0; mn1 = y1;
			end
			if (maj0 > maj1) begin
				t = maj0; maj0 = maj1; maj1 = t;
				t = mn0; mn0 = mn1; mn1 = t;
			end
			ln_major     = CB'(maj0);
			ln_minor     = CB'(mn0);
			ln_major_end = CB'(maj1);
			ln_dmaj      = 13'(maj1 - maj0);
			ln_minor_neg = mn1 < mn0;
			ln_dmin      = 13'(ln_minor_neg ? mn0 - mn1 : mn1 - mn0);
			ln_err       = 15'(2 * int'(ln_dmin) - int'(ln_dmaj));
			ln_color     = {c.r, c.g, c.b};
			ln_active    = 1'b1;
		end else if (ln_active) begin
			px = ln_y_major ? int'(ln_minor) : int'(ln_major);
			py = ln_y_major ? int'(ln_major) : int'(ln_minor);
			at_end = ln_major >= ln_major_end;
			p.x    = CB'(px);
			p.y    = CB'(py);
			p.r    = ln_color[23:16];
			p.g    = ln_color[15:8];
			p.b    = ln_color[7:0];
			p.vis  = px >= 0 && py >= 0 && px < int'(view_w) && py < int'(view_h);
			p.last = at_end;
			expected_pixels.insert(expected_pixels.size(), p);
			if (at_end) begin
				ln_active = 1'b0;
			end else begin
				e  = int'(ln_err);
				dn = int'(ln_dmin);
				dj = int'(ln_dmaj);
				ln_major = CB'(int'(ln_major) + 1);
				if (e > 0) begin
					ln_minor = CB'(ln_minor_neg ? int'(ln_minor) - 1 : int'(ln_minor) + 1);
					e = e + 2 * dn - 2 * dj;
				end else begin
					e = e + 2 * dn;
				end
				ln_err = 15'(e);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				rasterize_cmd(drv_cmd);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					drv_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= drv_cmd.cmd;
					s_tdata  <= {drv_cmd.b, drv_cmd.g, drv_cmd.r,
						drv_cmd.ey, drv_cmd.ex, drv_cmd.sy, drv_cmd.sx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(99) >= sink_stall_pct;
	end

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[11:0], m_tdata[23:12], m_tdata[31:24], m_tdata[39:32],
				m_tdata[47:40], m_tuser, m_tlast};
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d", $time,
					$signed(got.x), $signed(got.y));
				err_cnt++;
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					$display({"%0t: exp x=%0d y=%0d rgb=%h%h%h vis=%b last=%b,",
						" got x=%0d y=%0d rgb=%h%h%h vis=%b last=%b"},
						$time, $signed(want.x), $signed(want.y), want.r, want.g, want.b,
						want.vis, want.last, $signed(got.x), $signed(got.y), got.r, got.g,
						got.b, got.vis, got.last);
					err_cnt++;
				end
			end
		end
	end

	function automatic int clamp_coord(int v);
		return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
	endfunction

	function automatic int rand_axis(int lim);
		case ($urandom_range(3))
			0: return clamp_coord(int'($urandom_range(4095)) - 2048);
			1: return int'($urandom_range(80)) - 40;
			2: return clamp_coord(lim + int'($urandom_range(80)) - 40);
			default: return clamp_coord(int'($urandom_range(lim)));
		endcase
	endfunction

	task automatic push_start(input int x0, input int y0, input int x1, input int y1,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		line_cmd_t c;
		c.cmd = lrast_pkg::CMD_START;
		c.sx  = CB'(x0);
		c.sy  = CB'(y0);
		c.ex  = CB'(x1);
		c.ey  = CB'(y1);
		c.r   = r;
		c.g   = g;
		c.b   = b;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic push_steps(input int n);
		line_cmd_t c;
		repeat (n) begin
			c    = {1'b0, 32'($urandom), 32'($urandom), 8'($urandom)};
			c.cmd = lrast_pkg::CMD_STEP;
			pending_cmds.insert(pending_cmds.size(), c);
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_view(input logic [lrast_pkg::REG_ADDR_BITS-1:0] addr,
		input logic [lrast_pkg::VIEW_BITS-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == lrast_pkg::REG_VIEW_WIDTH)
			view_w = val;
		else
			view_h = val;
	endtask

	initial begin
		automatic int src_pct[4]  = '{0, 57, 0, 37};
		automatic int sink_pct[4] = '{0, 0, 57, 37};
		automatic int phase_w[8]  = '{4095, 1, 0, 2048, 1280, 0, 1, 640};
		automatic int phase_h[8]  = '{4095, 1, 2048, 0, 720, 0, 4095, 480};
		int x0, y0, x1, y1, dx, dy, ax, ay, len, n, k, made;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_steps(1);
		push_start(0, 0, 0, 0, 8'hff, 8'h00, 8'haa);
		push_steps(2);
		push_start(-2048, -2048, 2047, 2047, 8'h00, 8'hff, 8'h55);
		push_steps(2);
		push_start(2047, -2048, -2048, 2047, 8'h5a, 8'ha5, 8'hff);
		push_steps(2);
		push_start(2, 3, 0, 3, 8'h12, 8'h34, 8'h56);
		push_steps(3);
		push_start(3, -1, 3, 1, 8'h80, 8'h01, 8'h7f);
		push_steps(3);
		push_start(1279, 719, 1280, 720, 8'hc3, 8'h3c, 8'h00);
		push_steps(2);
		push_start(-2, 3, 3, 1, 8'h0f, 8'hf0, 8'h99);
		push_steps(6);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			src_idle_pct   = src_pct[p % 4];
			sink_stall_pct = sink_pct[p % 4];
			if (p == 5) begin
				phase_w[p] = $urandom_range(1, 300);
				phase_h[p] = $urandom_range(1, 300);
			end
			write_view(lrast_pkg::REG_VIEW_WIDTH, lrast_pkg::VIEW_BITS'(phase_w[p]));
			write_view(lrast_pkg::REG_VIEW_HEIGHT, lrast_pkg::VIEW_BITS'(phase_h[p]));
			made = 0;
			while (made < 110) begin
				if ($urandom_range(99) < 6) begin
					push_steps($urandom_range(1, 3));
				end else begin
					x0 = rand_axis(int'(view_w));
					y0 = rand_axis(int'(view_h));
					case ($urandom_range(19))
						0: begin
							dx = 0;
							dy = 0;
						end
						1, 2: begin
							dx = $urandom_range(1, 12);
							dy = 0;
						end
						3, 4: begin
							dx = 0;
							dy = $urandom_range(1, 12);
						end
						5, 6: begin
							dx = $urandom_range(1, 12);
							dy = dx;
						end
						7: begin
							dx = $urandom_range(300);
							dy = $urandom_range(300);
						end
						default: begin
							dx = $urandom_range(12);
							dy = $urandom_range(12);
						end
					endcase
					if ($urandom_range(1))
						dx = -dx;
					if ($urandom_range(1))
						dy = -dy;
					x1 = clamp_coord(x0 + dx);
					y1 = clamp_coord(y0 + dy);
					ax = x1 >= x0 ? x1 - x0 : x0 - x1;
					ay = y1 >= y0 ? y1 - y0 : y0 - y1;
					len = (ax > ay ? ax : ay) + 1;
					push_start(x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom));
					k = $urandom_range(99);
					if (k < 80)
						n = len;
					else if (k < 90)
						n = len + $urandom_range(1, 3);
					else
						n = $urandom_range(len - 1);
					push_steps(n);
					made += 1 + (n < len ? n : len);
				end
			end
			wait_idle();
		end

		if (err_cnt == 0 && expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/core/lrast_pkg.sv
rtl/core/lrast_front.sv
rtl/core/lrast_queue.sv
rtl/core/lrast_back.sv
rtl/core/line_rasterizer_top.sv
sim/line_rasterizer_top_test.sv
